### hw/rtl/scrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse constraint residual check package
// Codes, field widths and defaults shared by the residual check block.
// ----------------------------------------------------------------------------
package scrc_pkg;

    localparam int DEFAULT_MAX_VARIABLES = 1024;

    localparam int VALUE_W  = 32;  // Q16.16 operand
    localparam int WIDE_W   = 64;  // Q32.32 activity and violation
    localparam int INDEX_W  = 10;
    localparam int VCOUNT_W = 11;
    localparam int COUNT_W  = 32;
    localparam int WORST_W  = 63;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 192;

    // Configuration register indexes.
    localparam logic CFG_TOLERANCE      = 1'b0;
    localparam logic CFG_VARIABLE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_TERM  = 2'd1,
        FN_CLOSE = 2'd2,
        FN_CLEAR = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        SENSE_LE  = 2'd0,
        SENSE_GE  = 2'd1,
        SENSE_EQ  = 2'd2,
        SENSE_BAD = 2'd3
    } sense_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_SATISFIED = 3'd1,
        ST_VIOLATED  = 3'd2,
        ST_BAD_COL   = 3'd3,
        ST_BAD_SENSE = 3'd4,
        ST_FAILED    = 3'd5
    } status_t;

    localparam logic signed [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
    localparam logic [WIDE_W-1:0] MAG_ONE = 64'h0000_0001_0000_0000;  // 1.0 in Q32.32

endpackage

### hw/rtl/sparse_constraint_residual_check_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse constraint residual check
// Loads a candidate vector, accumulates sparse row activities and checks each
// closed row against its right-hand side within a relative tolerance.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry func in s_tuser and index, operand and sense in s_tdata.
//   Load beats fill the value store, term beats add coefficient times stored
//   value to the row activity, a close beat checks the row and a clear beat
//   resets the statistics and the sticky error.
//   Every input beat produces exactly one output beat: status in m_tuser and
//   the row violation with the running statistics in m_tdata.
//   The block is a five-register pipeline: store read, multiply, execute,
//   tolerance multiply, and output with the tolerance compare in front of it.
//   m_tvalid rises once the beat has passed through these registers, and one
//   beat can be accepted every cycle unless a stalled receiver has filled them.
//   Each stage moves up when the next one is empty or moving, so a stalled
//   receiver fills the pipeline bubbles first and s_tready drops only once
//   all five stages are full.
//   Reset clears the pipeline, the statistics, the error flag and both
//   configuration registers. The value store is not cleared; entries must be
//   loaded before a term reads them.
//   Configuration writes are taken in any cycle and must be made while idle.
// ----------------------------------------------------------------------------
module sparse_constraint_residual_check_top
    import scrc_pkg::*;
#(
    parameter int MAX_VARIABLES = DEFAULT_MAX_VARIABLES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // index[9:0], operand[41:10], sense[43:42]
    input  logic [1:0]            s_tuser,   // func[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // row_violation[63:0], fail_count[95:64],
                                             // check_count[127:96],
                                             // peak_violation[190:128]
    output logic [2:0]            m_tuser,   // status[2:0]
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [31:0]           cfg_data
);

    localparam int ADDR_W = $clog2(MAX_VARIABLES);

    // Configuration.
    logic [VALUE_W-1:0]  tol_reg;
    logic [VCOUNT_W-1:0] vcount_reg;

    // Stage enables and valids.
    logic en1, en2, en3, en4, en_o;
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic accept;

    // Value store.
    logic [VALUE_W-1:0] store_mem [MAX_VARIABLES];
    logic [VALUE_W-1:0] rd_reg;

    // Input fields.
    func_t               in_func;
    logic [INDEX_W-1:0]  in_index;
    logic [VALUE_W-1:0]  in_operand;
    sense_t              in_sense;

    // Stage 1: item and store data.
    func_t               func1_reg;
    logic [INDEX_W-1:0]  idx1_reg;
    logic [VALUE_W-1:0]  opnd1_reg;
    sense_t              sense1_reg;
    logic                colok1;

    // Stage 2: product.
    func_t                     func2_reg;
    logic signed [VALUE_W-1:0] opnd2_reg;
    sense_t                    sense2_reg;
    logic                      colok2_reg;
    logic signed [WIDE_W-1:0]  prod2_reg;

    // Execute state.
    logic signed [WIDE_W-1:0] act_reg, act_next;
    logic                     err_reg, err_next;

    // Execute results.
    logic signed [WIDE_W-1:0] rhs2;
    logic signed [WIDE_W:0]   sum65, diff65;
    logic signed [WIDE_W-1:0] sum_sat, diff_sat;
    logic [WIDE_W-1:0]        mag_act, mag_rhs, mag_max;
    status_t                  st3_next;
    logic                     close3_next, clear3_next;
    logic                     exec;

    // Stage 3.
    status_t                  st3_reg;
    logic                     close3_reg, clear3_reg, eq3_reg;
    logic signed [WIDE_W-1:0] diff3_reg;
    logic [WIDE_W-1:0]        mag3_reg;
    logic signed [WIDE_W-1:0] viol3;

    // Stage 4.
    status_t                  st4_reg;
    logic                     close4_reg, clear4_reg;
    logic signed [WIDE_W-1:0] viol4_reg;
    logic [WIDE_W-1:0]        phi4_reg, plo4_reg;
    logic [WIDE_W-1:0]        stol;
    logic                     violated4;

    // Output stage and statistics.
    status_t                  st_o_reg;
    logic signed [WIDE_W-1:0] viol_o_reg;
    logic [COUNT_W-1:0]       vcnt_reg, ccnt_reg;
    logic [WORST_W-1:0]       worst_reg;

    assign in_func    = func_t'(s_tuser);
    assign in_index   = s_tdata[9:0];
    assign in_operand = s_tdata[41:10];
    assign in_sense   = sense_t'(s_tdata[43:42]);

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= '0;
            vcount_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TOLERANCE:      tol_reg    <= cfg_data;
                CFG_VARIABLE_COUNT: vcount_reg <= cfg_data[VCOUNT_W-1:0];
                default:            tol_reg    <= tol_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    assign en_o     = !vo_reg || m_tready;
    assign en4      = !v4_reg || en_o;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en_o)
            begin
                vo_reg <= v4_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Value store: written by load beats, read for every accepted beat
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept && in_func == FN_LOAD && 32'(in_index) < 32'(MAX_VARIABLES))
        begin
            store_mem[ADDR_W'(in_index)] <= in_operand;
        end
        if (accept)
        begin
            rd_reg <= store_mem[ADDR_W'(in_index)];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 capture and stage 2 multiply
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func1_reg  <= in_func;
            idx1_reg   <= in_index;
            opnd1_reg  <= in_operand;
            sense1_reg <= in_sense;
        end
    end

    assign colok1 = ({1'b0, idx1_reg} < vcount_reg) &&
                    (32'(idx1_reg) < 32'(MAX_VARIABLES));

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            func2_reg  <= func1_reg;
            opnd2_reg  <= $signed(opnd1_reg);
            sense2_reg <= sense1_reg;
            colok2_reg <= colok1;
            prod2_reg  <= $signed(opnd1_reg) * $signed(rd_reg);
        end
    end

    // ------------------------------------------------------------------
    // Execute: activity, sticky error and the first half of a row check
    // ------------------------------------------------------------------
    assign exec = v2_reg && en3;
    assign rhs2 = {{16{opnd2_reg[VALUE_W-1]}}, opnd2_reg, 16'h0000};

    always_comb
    begin
        sum65 = {act_reg[WIDE_W-1], act_reg} + {prod2_reg[WIDE_W-1], prod2_reg};
        if (sum65[WIDE_W] != sum65[WIDE_W-1])
        begin
            sum_sat = sum65[WIDE_W] ? WIDE_MIN : WIDE_MAX;
        end
        else
        begin
            sum_sat = sum65[WIDE_W-1:0];
        end

        // At least rows measure rhs - activity; the others activity - rhs.
        if (sense2_reg == SENSE_GE)
        begin
            diff65 = {rhs2[WIDE_W-1], rhs2} - {act_reg[WIDE_W-1], act_reg};
        end
        else
        begin
            diff65 = {act_reg[WIDE_W-1], act_reg} - {rhs2[WIDE_W-1], rhs2};
        end
        if (diff65[WIDE_W] != diff65[WIDE_W-1])
        begin
            diff_sat = diff65[WIDE_W] ? WIDE_MIN : WIDE_MAX;
        end
        else
        begin
            diff_sat = diff65[WIDE_W-1:0];
        end

        mag_act = act_reg[WIDE_W-1] ? (WIDE_W'(0) - act_reg) : act_reg;
        mag_rhs = rhs2[WIDE_W-1] ? (WIDE_W'(0) - rhs2) : rhs2;
        mag_max = MAG_ONE;
        if (mag_act > mag_max)
        begin
            mag_max = mag_act;
        end
        if (mag_rhs > mag_max)
        begin
            mag_max = mag_rhs;
        end
    end

    always_comb
    begin
        act_next    = act_reg;
        err_next    = err_reg;
        st3_next    = ST_ACCEPTED;
        close3_next = 1'b0;
        clear3_next = 1'b0;
        if (exec)
        begin
            unique case (func2_reg)
                FN_LOAD:
                begin
                    st3_next = ST_ACCEPTED;
                end
                FN_CLEAR:
                begin
                    act_next    = '0;
                    err_next    = 1'b0;
                    clear3_next = 1'b1;
                end
                FN_TERM:
                begin
                    if (err_reg)
                    begin
                        st3_next = ST_FAILED;
                    end
                    else if (!colok2_reg)
                    begin
                        err_next = 1'b1;
                        st3_next = ST_BAD_COL;
                    end
                    else
                    begin
                        act_next = sum_sat;
                    end
                end
                FN_CLOSE:
                begin
                    if (err_reg)
                    begin
                        st3_next = ST_FAILED;
                    end
                    else if (sense2_reg == SENSE_BAD)
                    begin
                        err_next = 1'b1;
                        st3_next = ST_BAD_SENSE;
                    end
                    else
                    begin
                        act_next    = '0;
                        close3_next = 1'b1;
                    end
                end
                default:
                begin
                    st3_next = ST_ACCEPTED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= '0;
            err_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            st3_reg    <= st3_next;
            close3_reg <= close3_next;
            clear3_reg <= clear3_next;
            eq3_reg    <= (sense2_reg == SENSE_EQ);
            diff3_reg  <= diff_sat;
            mag3_reg   <= mag_max;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: final violation and tolerance partial products
    // ------------------------------------------------------------------
    always_comb
    begin
        viol3 = diff3_reg;
        if (eq3_reg && diff3_reg[WIDE_W-1])
        begin
            viol3 = (diff3_reg == WIDE_MIN) ? WIDE_MAX : (WIDE_W'(0) - diff3_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4 && v3_reg)
        begin
            st4_reg    <= st3_reg;
            close4_reg <= close3_reg;
            clear4_reg <= clear3_reg;
            viol4_reg  <= viol3;
            phi4_reg   <= tol_reg * mag3_reg[63:32];
            plo4_reg   <= tol_reg * mag3_reg[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: tolerance compare and row statistics
    // ------------------------------------------------------------------
    assign stol      = phi4_reg + {32'h0, plo4_reg[63:32]};
    assign violated4 = close4_reg && !viol4_reg[WIDE_W-1] && (viol4_reg != '0) &&
                       ($unsigned(viol4_reg) > stol);

    always_ff @(posedge clk)
    begin
        if (en_o && v4_reg)
        begin
            if (close4_reg)
            begin
                st_o_reg   <= violated4 ? ST_VIOLATED : ST_SATISFIED;
                viol_o_reg <= viol4_reg;
            end
            else
            begin
                st_o_reg   <= st4_reg;
                viol_o_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg  <= '0;
            ccnt_reg  <= '0;
            worst_reg <= '0;
        end
        else if (en_o && v4_reg)
        begin
            if (clear4_reg)
            begin
                vcnt_reg  <= '0;
                ccnt_reg  <= '0;
                worst_reg <= '0;
            end
            else if (close4_reg)
            begin
                if (ccnt_reg != '1)
                begin
                    ccnt_reg <= ccnt_reg + 1'b1;
                end
                if (violated4)
                begin
                    if (vcnt_reg != '1)
                    begin
                        vcnt_reg <= vcnt_reg + 1'b1;
                    end
                    if (viol4_reg[WORST_W-1:0] > worst_reg)
                    begin
                        worst_reg <= viol4_reg[WORST_W-1:0];
                    end
                end
            end
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tuser  = st_o_reg;
    assign m_tdata  = {1'b0, worst_reg, ccnt_reg, vcnt_reg, viol_o_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_viol_zero_unless_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_SATISFIED && m_tuser != ST_VIOLATED)
            |-> (m_tdata[63:0] == 64'h0))
        else $error("row violation nonzero on a beat that closed no row");

    a_violated_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_VIOLATED)
            |-> (!m_tdata[63] && m_tdata[63:0] != 64'h0 &&
                 {1'b0, m_tdata[190:128]} >= m_tdata[63:0]))
        else $error("violated row not reflected in maximum violation");

    a_err_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(err_reg) |-> $past(exec))
        else $error("error flag set without an executing beat");

    a_close_clears_activity: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && close3_next) |=> (act_reg == '0))
        else $error("activity not cleared after a row close");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && vo_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while the pipeline is full and stalled");

endmodule

### dv/row_check_mirror_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row check mirror
// Tracks the value store, the row activity and the row statistics of the
// residual check block, works out the answer for every input beat and
// compares the answers the block returns against them in order.
// ----------------------------------------------------------------------------
package row_check_mirror_pkg;

    import scrc_pkg::*;

    typedef struct {
        status_t     status;
        logic [63:0] violation;
        logic [31:0] violated;
        logic [31:0] closed;
        logic [62:0] worst;
    } row_answer_t;

    class row_check_mirror;

        logic [31:0] stored_value [DEFAULT_MAX_VARIABLES];
        longint      activity;
        logic [31:0] violated;
        logic [31:0] closed;
        logic [62:0] worst;
        bit          sticky_error;
        logic [31:0] tolerance;
        logic [10:0] col_limit;
        row_answer_t answers_due [$];
        int          mismatches;

        function new();
            activity     = 0;
            violated     = '0;
            closed       = '0;
            worst        = '0;
            sticky_error = 0;
            tolerance    = '0;
            col_limit    = '0;
            mismatches   = 0;
        endfunction

        function int pending();
            return answers_due.size();
        endfunction

        function void set_register(logic index, logic [31:0] data);
            if (index == CFG_TOLERANCE)
                tolerance = data;
            else
                col_limit = data[10:0];
        endfunction

        function longint sat_sum(longint a, longint b);
            logic [64:0] s;
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
                return s[64] ? WIDE_MIN : WIDE_MAX;
            return s[63:0];
        endfunction

        function longint sat_diff(longint a, longint b);
            logic [64:0] s;
            s = {a[63], a} - {b[63], b};
            if (s[64] != s[63])
                return s[64] ? WIDE_MIN : WIDE_MAX;
            return s[63:0];
        endfunction

        function logic [63:0] magnitude(longint a);
            logic [63:0] u;
            u = a;
            return u[63] ? -u : u;
        endfunction

        // Applies one accepted input beat and queues the answer it must produce.
        function void take_beat(func_t fn, logic [9:0] col, logic [31:0] operand,
                                sense_t sn);
            row_answer_t ans;
            longint      coef;
            longint      value;
            longint      rhs;
            longint      viol;
            logic [63:0] diff;
            logic [63:0] scale;
            logic [63:0] act_mag;
            logic [63:0] rhs_mag;
            logic [63:0] allowed;
            logic [63:0] viol_u;
            ans.status    = ST_ACCEPTED;
            ans.violation = '0;
            coef          = $signed(operand);
            case (fn)
                FN_LOAD:
                    stored_value[col] = operand;
                FN_CLEAR:
                begin
                    activity     = 0;
                    violated     = '0;
                    closed       = '0;
                    worst        = '0;
                    sticky_error = 0;
                end
                default:
                begin
                    if (sticky_error)
                        ans.status = ST_FAILED;
                    else if (fn == FN_TERM)
                    begin
                        if ({1'b0, col} >= col_limit)
                        begin
                            sticky_error = 1;
                            ans.status   = ST_BAD_COL;
                        end
                        else
                        begin
                            value    = $signed(stored_value[col]);
                            activity = sat_sum(activity, coef * value);
                        end
                    end
                    else if (sn == SENSE_BAD)
                    begin
                        sticky_error = 1;
                        ans.status   = ST_BAD_SENSE;
                    end
                    else
                    begin
                        rhs = coef * 65536;
                        case (sn)
                            SENSE_LE: viol = sat_diff(activity, rhs);
                            SENSE_GE: viol = sat_diff(rhs, activity);
                            default:
                            begin
                                diff = magnitude(sat_diff(activity, rhs));
                                viol = diff[63] ? WIDE_MAX : diff;
                            end
                        endcase
                        // The allowed slack scales with the larger of 1.0, |activity|
                        // and |rhs|, split into halves so the product fits 64 bits.
                        scale   = MAG_ONE;
                        act_mag = magnitude(activity);
                        rhs_mag = magnitude(rhs);
                        if (act_mag > scale)
                            scale = act_mag;
                        if (rhs_mag > scale)
                            scale = rhs_mag;
                        allowed = {32'b0, tolerance} * {32'b0, scale[63:32]}
                                + (({32'b0, tolerance} * {32'b0, scale[31:0]}) >> 32);
                        viol_u  = viol;
                        if (closed != '1)
                            closed++;
                        if (viol > 0 && viol_u > allowed)
                        begin
                            ans.status = ST_VIOLATED;
                            if (violated != '1)
                                violated++;
                            if (viol_u > {1'b0, worst})
                                worst = viol_u[62:0];
                        end
                        else
                            ans.status = ST_SATISFIED;
                        ans.violation = viol_u;
                        activity      = 0;
                    end
                end
            endcase
            ans.violated = violated;
            ans.closed   = closed;
            ans.worst    = worst;
            answers_due.insert(answers_due.size(), ans);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_answer(logic [2:0] status, logic [M_TDATA_W-1:0] data);
            row_answer_t want;
            if (answers_due.size() == 0)
            begin
                $error("result beat with nothing outstanding, status %0d", status);
                mismatches++;
                return;
            end
            want = answers_due.pop_front();
            check_field("status", want.status, status);
            check_field("row_violation", want.violation, data[63:0]);
            check_field("fail_count", want.violated, data[95:64]);
            check_field("check_count", want.closed, data[127:96]);
            check_field("peak_violation", want.worst, data[190:128]);
        endfunction

    endclass

endpackage

### dv/tb_sparse_constraint_residual_check_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse constraint residual check testbench
// Loads candidate values, streams sparse rows with random content, bad
// columns, bad senses and clears under several tolerance and variable count
// settings, with random gaps on the input and random stalls on the output.
// Every result beat is compared field by field with a mirror of the block.
// ----------------------------------------------------------------------------
module tb_sparse_constraint_residual_check_top;

    import scrc_pkg::*;
    import row_check_mirror_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BEATS = 150;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [2:0]           m_tuser;
    logic                 cfg_we    = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [31:0]          cfg_data  = '0;

    row_check_mirror mirror = new();

    // Stimulus-side copy of the store, used only to keep terms on loaded entries
    // and to aim right-hand sides near the row activity.
    logic [31:0] shadow_value [DEFAULT_MAX_VARIABLES];
    bit          shadow_loaded [DEFAULT_MAX_VARIABLES];
    int          loaded_cols [$];
    int          nvars_now = 0;
    int          sent = 0;
    bit          quiet = 0;
    int          idle_cycles = 0;

    sparse_constraint_residual_check_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                mirror.set_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                mirror.take_beat(func_t'(s_tuser), s_tdata[9:0], s_tdata[41:10],
                                 sense_t'(s_tdata[43:42]));
            if (m_tvalid && m_tready)
                mirror.compare_answer(m_tuser, m_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver: stalls in random bursts, with long stretches of steady ready.
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
                repeat (100) @(posedge clk);
            else
                repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return '0;
                endcase
            end
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic sense_t any_sense();
        return sense_t'($urandom_range(0, 3));
    endfunction

    task automatic send_item(input func_t fn, input logic [9:0] col,
                             input logic [31:0] operand, input sense_t sn);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, sn, operand, col};
        s_tuser  <= fn;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic load_value(input int col, input logic [31:0] value);
        send_item(FN_LOAD, col[9:0], value, any_sense());
        shadow_value[col] = value;
        if (!shadow_loaded[col])
        begin
            shadow_loaded[col] = 1;
            loaded_cols.insert(loaded_cols.size(), col);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (mirror.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_registers(input logic [31:0] tol, input int nvars);
        drain();
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_VARIABLE_COUNT, nvars);
        nvars_now = nvars;
    endtask

    // Returns a loaded column below the variable count, or -1 if none turns up.
    function automatic int pick_column();
        int k;
        int col;
        if (nvars_now == 0 || loaded_cols.size() == 0)
            return -1;
        for (k = 0; k < 6; k++)
        begin
            col = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
            if (col < nvars_now)
                return col;
        end
        return -1;
    endfunction

    task automatic send_row();
        int          n;
        int          k;
        int          col;
        int          jitter;
        logic [31:0] coef;
        logic [31:0] rhs;
        longint      act;
        longint      aim;
        sense_t      sn;
        act = 0;
        n   = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
        begin
            col = pick_column();
            // A fresh load right before its term reads the store just after a write.
            if (col < 0 || $urandom_range(0, 5) == 0)
            begin
                col = $urandom_range(0, nvars_now - 1);
                load_value(col, rand_operand());
            end
            coef = rand_operand();
            act += longint'($signed(coef)) * longint'($signed(shadow_value[col]));
            send_item(FN_TERM, col[9:0], coef, any_sense());
        end
        sn = ($urandom_range(0, 29) == 0) ? SENSE_BAD : sense_t'($urandom_range(0, 2));
        if ($urandom_range(0, 2) == 0)
            rhs = rand_operand();
        else
        begin
            jitter = $urandom_range(0, 64);
            aim    = (act >>> 16) + jitter - 32;
            if (aim != longint'($signed(aim[31:0])))
                rhs = (aim < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                rhs = aim[31:0];
        end
        send_item(FN_CLOSE, 10'($urandom_range(0, 1023)), rhs, sn);
    endtask

    task automatic run_phase(input int beats);
        int first;
        int pick;
        int col;
        first = sent;
        while (sent - first < beats)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_row();
            else if (pick < 75)
                load_value($urandom_range(0, 1023), rand_operand());
            else if (pick < 83)
            begin
                repeat ($urandom_range(2, 6))
                    load_value($urandom_range(0, nvars_now - 1), rand_operand());
            end
            else if (pick < 88)
                send_item(FN_CLEAR, 10'($urandom_range(0, 1023)), $urandom(), any_sense());
            else if (pick < 96)
            begin
                if (pick < 92 && nvars_now < DEFAULT_MAX_VARIABLES)
                    send_item(FN_TERM, 10'($urandom_range(nvars_now, 1023)),
                              rand_operand(), any_sense());
                else
                    send_item(FN_CLOSE, 10'($urandom_range(0, 1023)), rand_operand(),
                              any_sense());
                // Errors are sticky, so half of them, picked at random, are cleared right away.
                if ($urandom_range(0, 1) == 0)
                    send_item(FN_CLEAR, 10'($urandom_range(0, 1023)), $urandom(),
                              any_sense());
            end
            else
            begin
                col = pick_column();
                if (col >= 0)
                    send_item(FN_TERM, col[9:0], rand_operand(), any_sense());
            end
        end
    endtask

    initial
    begin
        int p;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extreme operands, saturation both ways, every sense,
        // the sticky error, loads during an error, clear and bad columns.
        program_registers(32'h0, 1024);
        load_value(0, 32'h7FFF_FFFF);
        load_value(1023, 32'h8000_0000);
        load_value(1, 32'h0001_0000);
        repeat (3) send_item(FN_TERM, 10'd0, 32'h7FFF_FFFF, SENSE_LE);
        send_item(FN_CLOSE, 10'd0, 32'h0, SENSE_EQ);
        repeat (3) send_item(FN_TERM, 10'd1023, 32'h7FFF_FFFF, SENSE_LE);
        send_item(FN_CLOSE, 10'd0, 32'h7FFF_FFFF, SENSE_GE);
        send_item(FN_TERM, 10'd1023, 32'h8000_0000, SENSE_LE);
        send_item(FN_CLOSE, 10'd0, 32'h8000_0000, SENSE_LE);
        repeat (3) send_item(FN_TERM, 10'd1023, 32'h7FFF_FFFF, SENSE_LE);
        send_item(FN_CLOSE, 10'd0, 32'h7FFF_FFFF, SENSE_EQ);
        send_item(FN_TERM, 10'd1, 32'h0001_0000, SENSE_LE);
        send_item(FN_CLOSE, 10'd0, 32'h0001_0000, SENSE_LE);
        send_item(FN_CLOSE, 10'd0, 32'h0, SENSE_BAD);
        send_item(FN_TERM, 10'd1, 32'h0001_0000, SENSE_LE);
        send_item(FN_CLOSE, 10'd0, 32'h0, SENSE_LE);
        load_value(2, 32'hFFFF_FFFF);
        send_item(FN_CLEAR, 10'd0, 32'h0, SENSE_LE);
        program_registers(32'hFFFF_FFFF, 0);
        send_item(FN_TERM, 10'd0, 32'h0001_0000, SENSE_LE);
        send_item(FN_CLEAR, 10'd0, 32'h0, SENSE_LE);

        for (p = 0; p < 8; p++)
        begin
            case (p)
                0: program_registers(32'h0, 1024);
                1: program_registers(32'hFFFF_FFFF, 1024);
                2: program_registers($urandom_range(0, 32'h0001_0000),
                                     $urandom_range(1, 1024));
                3: program_registers($urandom(), 2);
                4: program_registers($urandom_range(0, 32'h0100_0000), 1);
                5: program_registers($urandom(), $urandom_range(1, 1024));
                6: program_registers(32'h0000_1000, 512);
                default:
                begin
                    program_registers($urandom(), 1024);
                    quiet = 1;
                end
            endcase
            run_phase(PHASE_BEATS);
        end

        drain();
        repeat (20) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
